FILE: sv/pixel_blend_unit_defines.svh
// ----------------------------------------------------------------------------
// pixel_blend_unit_defines
// assertion macros shared by the pixel blend unit; they expect clk and rst_n
// in the scope where they are used
// ----------------------------------------------------------------------------
`ifndef PIXEL_BLEND_UNIT_DEFINES_SVH
`define PIXEL_BLEND_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PBU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define PBU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pbu_pkg.sv
// ----------------------------------------------------------------------------
// pbu_pkg
// shared types, mode codes, reset values and the divide-by-255 helper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbu_pkg;

    // mode codes carried by a request
    localparam logic [3:0] MODE_MUL     = 4'd0;
    localparam logic [3:0] MODE_SCR     = 4'd1;
    localparam logic [3:0] MODE_SUB     = 4'd2;
    localparam logic [3:0] MODE_OVL     = 4'd3;
    localparam logic [3:0] MODE_GBOOST  = 4'd4;
    localparam logic [3:0] MODE_RGAIN   = 4'd5;
    localparam logic [3:0] MODE_REP_B   = 4'd6;
    localparam logic [3:0] MODE_REP_G   = 4'd7;
    localparam logic [3:0] MODE_REP_R   = 4'd8;

    // configuration register indexes
    localparam logic [3:0] REG_GREEN_OFFSET = 4'd0;
    localparam logic [3:0] REG_RED_GAIN     = 4'd1;

    // register reset values
    localparam logic [7:0] GREEN_OFFSET_RST = 8'd200;
    localparam logic [3:0] RED_GAIN_RST     = 4'd4;

    localparam logic [7:0] CH_MAX = 8'd255;

    // one rgb pixel
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_t;

    // floor(x / 255) by two fold-back steps and one final compare
    function automatic logic [8:0] div255(input logic [17:0] x);
        logic [9:0]  q0;
        logic [10:0] r1;
        logic [2:0]  q1;
        logic [8:0]  r2;
        logic [9:0]  q;
        q0 = x[17:8];
        r1 = {3'b0, x[7:0]} + {1'b0, q0};
        q1 = r1[10:8];
        r2 = {1'b0, r1[7:0]} + {6'b0, q1};
        q  = q0 + {7'b0, q1} + {9'b0, (r2 >= 9'd255)};
        return q[8:0];
    endfunction

endpackage

FILE: sv/pbu_lane.sv
// ----------------------------------------------------------------------------
// pbu_lane
// one colour channel of the two-layer blends: product stage, then
// rounded divide by 255 and mode-specific finish
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbu_lane
(
    input  logic       clk,
    input  logic [3:0] mode,
    input  logic [7:0] a,
    input  logic [7:0] b,
    output logic [7:0] result
);

    typedef enum logic [2:0] {
        OP_MUL,
        OP_SCR,
        OP_SUB,
        OP_OVL_LO,
        OP_OVL_HI,
        OP_NONE
    } lane_op_t;

    lane_op_t    op_next;
    lane_op_t    op_reg;
    logic [7:0]  opa;
    logic [7:0]  opb;
    logic [15:0] prod_next;
    logic [15:0] prod_reg;
    logic [7:0]  diff_next;
    logic [7:0]  diff_reg;
    logic [17:0] num;
    logic [8:0]  quo;

    // operand selection: inverted operands for the screen side
    always_comb
    begin
        op_next = OP_NONE;
        opa     = a;
        opb     = b;
        case (mode)
            pbu_pkg::MODE_MUL:
            begin
                op_next = OP_MUL;
            end
            pbu_pkg::MODE_SCR:
            begin
                op_next = OP_SCR;
                opa     = ~a;
                opb     = ~b;
            end
            pbu_pkg::MODE_SUB:
            begin
                op_next = OP_SUB;
            end
            pbu_pkg::MODE_OVL:
            begin
                if (b[7])
                begin
                    op_next = OP_OVL_HI;
                    opa     = ~a;
                    opb     = ~b;
                end
                else
                begin
                    op_next = OP_OVL_LO;
                end
            end
            default:
            begin
                op_next = OP_NONE;
            end
        endcase
        prod_next = 16'(opa) * 16'(opb);
        diff_next = (b > a) ? (b - a) : 8'd0;
    end

    // product stage
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        prod_reg <= prod_next;
        diff_reg <= diff_next;
    end

    // rounded divide: overlay uses the doubled product
    always_comb
    begin
        if (op_reg == OP_OVL_LO || op_reg == OP_OVL_HI)
        begin
            num = {1'b0, prod_reg, 1'b0} + 18'd127;
        end
        else
        begin
            num = {2'b0, prod_reg} + 18'd127;
        end
        quo = pbu_pkg::div255(num);
    end

    // finish per operation
    always_comb
    begin
        case (op_reg)
            OP_MUL:    result = quo[7:0];
            OP_SCR:    result = pbu_pkg::CH_MAX - quo[7:0];
            OP_OVL_HI: result = pbu_pkg::CH_MAX - quo[7:0];
            OP_OVL_LO: result = quo[8] ? pbu_pkg::CH_MAX : quo[7:0];
            OP_SUB:    result = diff_reg;
            default:   result = 8'd0;
        endcase
    end

endmodule

FILE: sv/pbu_merge.sv
// ----------------------------------------------------------------------------
// pbu_merge
// tracks requests through the pipe, forms the single-layer effects and
// merges them with the lane results into the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "pixel_blend_unit_defines.svh"

module pbu_merge
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic [3:0]   mode,
    input  pbu_pkg::pix_t pix_a,
    input  pbu_pkg::pix_t lane_res,
    input  logic [7:0]   green_offset,
    input  logic [3:0]   red_gain,
    output logic         done,
    output pbu_pkg::pix_t pix_out
);

    logic          v1_reg;
    logic [3:0]    mode_reg;
    pbu_pkg::pix_t a_reg;
    logic          done_reg;
    pbu_pkg::pix_t out_reg;
    pbu_pkg::pix_t out_next;
    logic [8:0]    gsum;
    logic [11:0]   rprod;
    logic [7:0]    gsat;
    logic [7:0]    rsat;

    // single-layer effects
    always_comb
    begin
        gsum = {1'b0, a_reg.green} + {1'b0, green_offset};
        gsat = gsum[8] ? pbu_pkg::CH_MAX : gsum[7:0];
        rprod = 12'(a_reg.red) * 12'(red_gain);
        rsat = (rprod > 12'd255) ? pbu_pkg::CH_MAX : rprod[7:0];
    end

    // output selection
    always_comb
    begin
        out_next = a_reg;
        case (mode_reg) inside
            pbu_pkg::MODE_MUL, pbu_pkg::MODE_SCR,
            pbu_pkg::MODE_SUB, pbu_pkg::MODE_OVL:
            begin
                out_next = lane_res;
            end
            pbu_pkg::MODE_GBOOST:
            begin
                out_next.green = gsat;
            end
            pbu_pkg::MODE_RGAIN:
            begin
                out_next.blue = 8'd0;
                out_next.red  = rsat;
            end
            pbu_pkg::MODE_REP_B:
            begin
                out_next.green = a_reg.blue;
                out_next.red   = a_reg.blue;
            end
            pbu_pkg::MODE_REP_G:
            begin
                out_next.blue = a_reg.green;
                out_next.red  = a_reg.green;
            end
            pbu_pkg::MODE_REP_R:
            begin
                out_next.blue  = a_reg.red;
                out_next.green = a_reg.red;
            end
            default:
            begin
                out_next = a_reg;
            end
        endcase
    end

    // request tracking and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            done_reg <= v1_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mode_reg <= mode;
        a_reg    <= pix_a;
        out_reg  <= out_next;
    end

    assign done    = done_reg;
    assign pix_out = out_reg;

    // checks
    `PBU_ASSERT_NEXT(a_request_emerges, v1_reg, done_reg, "request lost in pipe")
    `PBU_ASSERT_NOW(a_strobe_follows, done_reg, $past(v1_reg), "strobe without request")
    `PBU_ASSERT_NEXT(a_rgain_blue, v1_reg && mode_reg == pbu_pkg::MODE_RGAIN,
                     out_reg.blue == 8'd0, "red gain left blue set")
    `PBU_ASSERT_NEXT(a_rep_red, v1_reg && mode_reg == pbu_pkg::MODE_REP_R,
                     out_reg.blue == out_reg.red && out_reg.green == out_reg.red,
                     "replicate red mismatch")

endmodule

FILE: sv/pixel_blend_unit.sv
// Pipeline: a request accepted at a clock edge passes the product stage in the lanes, then
// the divide and merge into the output register, and done strobes with that result.
// Throughput: one pixel per clock; busy is never raised and the receiver cannot stall.
// Reset: rst_n clears the pipe valids and sets green_offset to 200, red_gain to 4.
// ----------------------------------------------------------------------------
// pixel_blend_unit
// three channel lanes for the two-layer blends plus a merge stage for the
// single-layer effects, with a small configuration register file
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_blend_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [3:0] mode,
    input  logic [7:0] layer_a_blue,
    input  logic [7:0] layer_a_green,
    input  logic [7:0] layer_a_red,
    input  logic [7:0] layer_b_blue,
    input  logic [7:0] layer_b_green,
    input  logic [7:0] layer_b_red,
    output logic       done,
    output logic [7:0] out_blue,
    output logic [7:0] out_green,
    output logic [7:0] out_red,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic [7:0]    green_offset_reg;
    logic [3:0]    red_gain_reg;
    logic          accept;
    pbu_pkg::pix_t pix_a;
    pbu_pkg::pix_t lane_res;
    pbu_pkg::pix_t pix_out;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    assign pix_a.blue  = layer_a_blue;
    assign pix_a.green = layer_a_green;
    assign pix_a.red   = layer_a_red;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            green_offset_reg <= pbu_pkg::GREEN_OFFSET_RST;
            red_gain_reg     <= pbu_pkg::RED_GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pbu_pkg::REG_GREEN_OFFSET: green_offset_reg <= cfg_data;
                pbu_pkg::REG_RED_GAIN:     red_gain_reg     <= cfg_data[3:0];
                default:                   ;
            endcase
        end
    end

    // channel lanes
    pbu_lane u_lane_blue
    (
        .clk    (clk),
        .mode   (mode),
        .a      (layer_a_blue),
        .b      (layer_b_blue),
        .result (lane_res.blue)
    );

    pbu_lane u_lane_green
    (
        .clk    (clk),
        .mode   (mode),
        .a      (layer_a_green),
        .b      (layer_b_green),
        .result (lane_res.green)
    );

    pbu_lane u_lane_red
    (
        .clk    (clk),
        .mode   (mode),
        .a      (layer_a_red),
        .b      (layer_b_red),
        .result (lane_res.red)
    );

    // merge and output register
    pbu_merge u_merge
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .mode         (mode),
        .pix_a        (pix_a),
        .lane_res     (lane_res),
        .green_offset (green_offset_reg),
        .red_gain     (red_gain_reg),
        .done         (done),
        .pix_out      (pix_out)
    );

    assign out_blue  = pix_out.blue;
    assign out_green = pix_out.green;
    assign out_red   = pix_out.red;

endmodule
